### hdl/fts_pkg.sv
package fts_pkg;

  // Default width of the time base in bits.
  localparam int TIME_WIDTH_DEF = 48;

  // Field widths on the channels.
  localparam int NOW_W      = 48;
  localparam int REQ_W      = 32;
  localparam int KIND_W     = 3;
  localparam int INTERVAL_W = 16;
  localparam int MAXSTEP_W  = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Packed widths of tdata, padded to whole bytes.
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_BEGIN_FRAME = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN_PHASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POLL        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUEUE       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SET_PAUSE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SINGLE_STEP = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RESTART     = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 4'd1;

  // Reset values of the configuration registers.
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd16;
  localparam logic [MAXSTEP_W-1:0]  MAXSTEP_RST  = 8'd5;

  // Saturation value of the manual step queue.
  localparam logic [REQ_W-1:0] QUEUE_MAX = {REQ_W{1'b1}};

endpackage

### hdl/fixed_timestep_scheduler.sv
// Fixed-timestep scheduler with a catch-up limit.
//
// Requests arrive on the in_ channel; in_tuser carries the request kind
// (begin frame, begin fixed phase, poll, queue steps, set pause, request
// single step, restart) and in_tdata carries the time stamp, the step count
// and the pause value. Every request yields exactly one result on the out_
// channel: the update grant, the pause and single-step flags and the number
// of manual steps still queued.
// The interval and the per-phase cap are written on the cfg_ channel, which
// is always ready; write them only while no request is in flight.
// Each request passes one input register, then the state update and the
// result register. One request is accepted per cycle while results are
// taken; the single state update, one subtract and compare on the time
// base plus a 16x8 product, sets that rate.
// When the receiver stalls, the result holds and one more request may enter
// the input register; after that in_tready drops until the result is taken.
// Reset empties both registers, clears the scheduler state and restores the
// interval to 16 ms and the cap to 5 steps.
module fixed_timestep_scheduler #(
  parameter int TIME_WIDTH = fts_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: now_ms [47:0], step_request [79:48], pause_value [80], zeros above.
  input  logic [fts_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: kind [2:0].
  input  logic [fts_pkg::KIND_W-1:0]      in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: do_update [0], paused_now [1], single_step_pending [2],
  // queued_left [34:3], zeros above.
  output logic [fts_pkg::OUT_DATA_W-1:0]  out_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import fts_pkg::*;

  localparam int PROD_W = INTERVAL_W + MAXSTEP_W;
  localparam int CMP_W  = (TIME_WIDTH > PROD_W) ? TIME_WIDTH : PROD_W;

  // Configuration registers.
  logic [INTERVAL_W-1:0] interval_r;
  logic [MAXSTEP_W-1:0]  max_steps_r;

  // Input register.
  logic                  s1_valid_r;
  logic [KIND_W-1:0]     s1_kind_r;
  logic [NOW_W-1:0]      s1_now_r;
  logic [REQ_W-1:0]      s1_req_r;
  logic                  s1_pause_r;

  // Scheduler state.
  logic [TIME_WIDTH-1:0] next_due_r, next_due_nxt;
  logic [MAXSTEP_W-1:0]  steps_r, steps_nxt;
  logic [REQ_W-1:0]      queued_r, queued_nxt;
  logic                  paused_r, paused_nxt;
  logic                  single_r, single_nxt;
  logic                  upd_nxt;

  // Result register.
  logic                  out_valid_r;
  logic                  out_upd_r;
  logic                  out_paused_r;
  logic                  out_single_r;
  logic [REQ_W-1:0]      out_queued_r;

  logic                  out_free;
  logic                  s1_fire;
  logic [63:0]           now_ext;
  logic [TIME_WIDTH-1:0] now_tw;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [PROD_W-1:0]     catchup_span;
  logic                  lagging;
  logic                  not_due;
  logic                  capped;
  logic [REQ_W:0]        queue_sum;

  // Handshakes.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= INTERVAL_RST;
      max_steps_r <= MAXSTEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INTERVAL:  interval_r  <= cfg_data;
        REG_MAX_STEPS: max_steps_r <= cfg_data[MAXSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r  <= in_tuser;
      s1_now_r   <= in_tdata[NOW_W-1:0];
      s1_req_r   <= in_tdata[NOW_W+REQ_W-1:NOW_W];
      s1_pause_r <= in_tdata[NOW_W+REQ_W];
    end
  end

  // Time arithmetic, modulo the time base.
  assign now_ext      = {{(64-NOW_W){1'b0}}, s1_now_r};
  assign now_tw       = now_ext[TIME_WIDTH-1:0];
  assign elapsed      = now_tw - next_due_r;
  assign catchup_span = PROD_W'(interval_r) * PROD_W'(max_steps_r);
  assign lagging      = CMP_W'(elapsed) > CMP_W'(catchup_span);
  assign not_due      = elapsed < TIME_WIDTH'(interval_r);
  assign capped       = steps_r >= max_steps_r;
  assign queue_sum    = {1'b0, queued_r} + {1'b0, s1_req_r};

  // Next state and grant for the request in the input register.
  always_comb begin
    next_due_nxt = next_due_r;
    steps_nxt    = steps_r;
    queued_nxt   = queued_r;
    paused_nxt   = paused_r;
    single_nxt   = single_r;
    upd_nxt      = 1'b0;
    case (s1_kind_r)
      KIND_BEGIN_FRAME: begin
        if (paused_r && single_r) paused_nxt = 1'b0;
      end
      KIND_BEGIN_PHASE: begin
        if (lagging) next_due_nxt = now_tw;
        steps_nxt = '0;
      end
      KIND_POLL: begin
        if (queued_r != '0) begin
          // A queued manual step obeys only the per-phase cap.
          if (!capped) begin
            queued_nxt   = queued_r - 1'b1;
            upd_nxt      = 1'b1;
            next_due_nxt = next_due_r + TIME_WIDTH'(interval_r);
            steps_nxt    = steps_r + 1'b1;
          end
        end else if (!(paused_r && !single_r)) begin
          if (not_due || capped) begin
            // A single step that cannot run pauses again.
            if (single_r && !paused_r) begin
              paused_nxt = 1'b1;
              single_nxt = 1'b0;
            end
          end else begin
            upd_nxt      = 1'b1;
            next_due_nxt = next_due_r + TIME_WIDTH'(interval_r);
            steps_nxt    = steps_r + 1'b1;
          end
        end
      end
      KIND_QUEUE: begin
        if (paused_r && s1_req_r != '0) begin
          queued_nxt = queue_sum[REQ_W] ? QUEUE_MAX : queue_sum[REQ_W-1:0];
        end
      end
      KIND_SET_PAUSE: begin
        paused_nxt = s1_pause_r;
      end
      KIND_SINGLE_STEP: begin
        single_nxt = 1'b1;
      end
      KIND_RESTART: begin
        steps_nxt    = '0;
        queued_nxt   = '0;
        next_due_nxt = now_tw;
        paused_nxt   = 1'b0;
        single_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  // State update, one request per cycle while the result register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_due_r <= '0;
      steps_r    <= '0;
      queued_r   <= '0;
      paused_r   <= 1'b0;
      single_r   <= 1'b0;
    end else if (s1_fire) begin
      next_due_r <= next_due_nxt;
      steps_r    <= steps_nxt;
      queued_r   <= queued_nxt;
      paused_r   <= paused_nxt;
      single_r   <= single_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_upd_r    <= upd_nxt;
      out_paused_r <= paused_nxt;
      out_single_r <= single_nxt;
      out_queued_r <= queued_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-REQ_W-3){1'b0}}, out_queued_r,
                       out_single_r, out_paused_r, out_upd_r};

endmodule

### hdl/fts_checker.sv
module fts_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fts_pkg::OUT_DATA_W-1:0] out_tdata
);

  import fts_pkg::*;

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // With the result register empty, the pipeline must take a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request refused while result register is empty");

  // The padding above the queue count stays zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:REQ_W+3] == '0)
    else $error("nonzero padding in result");

endmodule

bind fixed_timestep_scheduler fts_checker u_fts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
